/* design/nfpa_pkg.sv */
package nfpa_pkg;

    localparam int BYTES_W      = 20;
    localparam int FPAGE_W      = 12;
    localparam int START_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int STATUS_W     = 2;
    localparam int CFG_W        = 13;
    localparam int HEADER_BYTES = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OOM       = 2'd1,
        STAT_NOT_ALLOC = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_ALLOC,
        RES_OOM,
        RES_BAD_FREE,
        RES_FREED
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_CLR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic wrap;
        logic scan_start;
        logic scan_hit;
        logic scan_next;
        logic mark_start;
        logic mark_step;
        logic free_start;
        logic free_step;
        logic res_load;
        res_t res_sel;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic fit_fail;
        logic oom;
        logic scan_end;
        logic page_busy;
        logic mark_last;
        logic free_bad;
        logic free_end;
    } sts_t;

endpackage

/* design/nfpa_req_if.sv */
interface nfpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [nfpa_pkg::BYTES_W-1:0] request_bytes;
    logic [nfpa_pkg::FPAGE_W-1:0] free_page;

    modport source (output valid, command, request_bytes, free_page, input ready);
    modport sink   (input valid, command, request_bytes, free_page, output ready);
endinterface

/* design/nfpa_rsp_if.sv */
interface nfpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nfpa_pkg::START_W-1:0]  first_page;
    logic [nfpa_pkg::COUNT_W-1:0]  page_count;
    logic [nfpa_pkg::STATUS_W-1:0] status;

    modport source (output valid, first_page, page_count, status, input ready);
    modport sink   (input valid, first_page, page_count, status, output ready);
endinterface

/* design/nfpa_ram.sv */
module nfpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/nfpa_ctrl.sv */
module nfpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  nfpa_pkg::sts_t sts,
    output nfpa_pkg::cmd_t cmd
);

    nfpa_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfpa_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = nfpa_pkg::RES_OOM;
        in_ready   = 1'b0;
        unique case (state_reg)
            nfpa_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = nfpa_pkg::S_IDLE;
                end
            end
            nfpa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = nfpa_pkg::S_DECODE;
                end
            end
            nfpa_pkg::S_DECODE:
            begin
                if (sts.is_free)
                begin
                    state_next = nfpa_pkg::S_FREE_RD;
                end
                else
                begin
                    state_next = nfpa_pkg::S_CHECK;
                end
            end
            nfpa_pkg::S_CHECK:
            begin
                if (sts.fit_fail)
                begin
                    if (sts.oom)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = nfpa_pkg::RES_OOM;
                        state_next   = nfpa_pkg::S_RESP;
                    end
                    else
                    begin
                        cmd.wrap = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = nfpa_pkg::S_SCAN_RD;
                end
            end
            nfpa_pkg::S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = nfpa_pkg::S_MARK;
                end
                else
                begin
                    state_next = nfpa_pkg::S_SCAN_CHK;
                end
            end
            nfpa_pkg::S_SCAN_CHK:
            begin
                if (sts.page_busy)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = nfpa_pkg::S_CHECK;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = nfpa_pkg::S_SCAN_RD;
                end
            end
            nfpa_pkg::S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = nfpa_pkg::RES_ALLOC;
                    state_next   = nfpa_pkg::S_RESP;
                end
            end
            nfpa_pkg::S_FREE_RD:
            begin
                state_next = nfpa_pkg::S_FREE_CHK;
            end
            nfpa_pkg::S_FREE_CHK:
            begin
                if (sts.free_bad)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = nfpa_pkg::RES_BAD_FREE;
                    state_next   = nfpa_pkg::S_RESP;
                end
                else
                begin
                    cmd.free_start = 1'b1;
                    state_next     = nfpa_pkg::S_FREE_CLR;
                end
            end
            nfpa_pkg::S_FREE_CLR:
            begin
                if (sts.free_end)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = nfpa_pkg::RES_FREED;
                    state_next   = nfpa_pkg::S_RESP;
                end
                else
                begin
                    cmd.free_step = 1'b1;
                end
            end
            nfpa_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nfpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

/* design/nfpa_dp.sv */
module nfpa_dp #(
    parameter int PAGES      = 4096,
    parameter int PAGE_BYTES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [nfpa_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          command,
    input  logic [nfpa_pkg::BYTES_W-1:0]  request_bytes,
    input  logic [nfpa_pkg::FPAGE_W-1:0]  free_page,
    output logic [nfpa_pkg::START_W-1:0]  first_page,
    output logic [nfpa_pkg::COUNT_W-1:0]  page_count,
    output logic [nfpa_pkg::STATUS_W-1:0] status,
    input  nfpa_pkg::cmd_t                cmd,
    output nfpa_pkg::sts_t                sts
);

    localparam int PW = $clog2(PAGES);
    localparam int AW = PW + 1;
    localparam int LW = $clog2(PAGES + 1);
    localparam int DW = $clog2((1 << nfpa_pkg::BYTES_W) + nfpa_pkg::HEADER_BYTES + PAGE_BYTES);
    localparam int PB_SH = $clog2(PAGE_BYTES);
    localparam int WW = DW + 2;

    logic [nfpa_pkg::CFG_W-1:0] pages_reg;
    logic [PW-1:0]              clr_addr_reg;
    logic [AW-1:0]              cursor_reg;

    logic                       is_free_reg;
    logic [nfpa_pkg::FPAGE_W-1:0] fpage_reg;
    logic [DW-1:0]              q_reg, q_next;
    logic                       wrapped_reg;
    logic [AW-1:0]              cur_reg, cur_next;
    logic [AW-1:0]              i_reg, i_next;
    logic [LW-1:0]              len_reg;

    logic [nfpa_pkg::START_W-1:0]  res_start_reg, out_start_reg;
    logic [nfpa_pkg::COUNT_W-1:0]  res_count_reg, out_count_reg;
    nfpa_pkg::status_t             res_status_reg, out_status_reg;

    logic [WW-1:0] mp_w, pages_w, cur_w, cnt_w, i_w, end_w, fpage_w, fend_w, total_w;

    logic          page_we;
    logic [PW-1:0] page_waddr;
    logic          page_rdata;
    logic          mark_we;
    logic [PW-1:0] mark_waddr;
    logic [LW:0]   mark_wdata, mark_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg    <= nfpa_pkg::CFG_RESET;
            clr_addr_reg <= '0;
            cursor_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                pages_reg <= cfg_write_data;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.res_load && cmd.res_sel == nfpa_pkg::RES_ALLOC)
            begin
                cursor_reg <= AW'(end_w);
            end
        end
    end

    assign pages_w = WW'(pages_reg);
    assign mp_w    = (pages_w < WW'(2)) ? WW'(2)
                   : ((pages_w > WW'(PAGES)) ? WW'(PAGES) : pages_w);
    assign cur_w   = WW'(cur_reg);
    assign cnt_w   = WW'(q_reg);
    assign i_w     = WW'(i_reg);
    assign end_w   = cur_w + cnt_w;
    assign fpage_w = WW'(fpage_reg);
    assign fend_w  = fpage_w + WW'(len_reg);
    assign total_w = WW'(request_bytes) + WW'(nfpa_pkg::HEADER_BYTES) + WW'(PAGE_BYTES - 1);

    always_comb
    begin
        q_next = q_reg;
        if (cmd.load)
        begin
            q_next = DW'(total_w >> PB_SH);
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        i_next   = i_reg;
        if (cmd.load)
        begin
            cur_next = cursor_reg;
        end
        else if (cmd.wrap)
        begin
            cur_next = '0;
        end
        else if (cmd.scan_hit)
        begin
            cur_next = AW'(i_w + WW'(1));
        end
        if (cmd.scan_start || cmd.mark_start)
        begin
            i_next = cur_reg;
        end
        else if (cmd.free_start)
        begin
            i_next = AW'(fpage_w);
        end
        else if (cmd.scan_next || cmd.mark_step || cmd.free_step)
        begin
            i_next = AW'(i_w + WW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        cur_reg <= cur_next;
        i_reg   <= i_next;
        if (cmd.load)
        begin
            is_free_reg <= command;
            fpage_reg   <= free_page;
            wrapped_reg <= 1'b0;
        end
        else if (cmd.wrap)
        begin
            wrapped_reg <= 1'b1;
        end
        if (cmd.free_start)
        begin
            len_reg <= mark_rdata[LW-1:0];
        end
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                nfpa_pkg::RES_ALLOC:
                begin
                    res_start_reg  <= nfpa_pkg::START_W'(cur_w);
                    res_count_reg  <= nfpa_pkg::COUNT_W'(cnt_w);
                    res_status_reg <= nfpa_pkg::STAT_OK;
                end
                nfpa_pkg::RES_OOM:
                begin
                    res_start_reg  <= '0;
                    res_count_reg  <= '0;
                    res_status_reg <= nfpa_pkg::STAT_OOM;
                end
                nfpa_pkg::RES_BAD_FREE:
                begin
                    res_start_reg  <= '0;
                    res_count_reg  <= '0;
                    res_status_reg <= nfpa_pkg::STAT_NOT_ALLOC;
                end
                nfpa_pkg::RES_FREED:
                begin
                    res_start_reg  <= '0;
                    res_count_reg  <= nfpa_pkg::COUNT_W'(WW'(len_reg));
                    res_status_reg <= nfpa_pkg::STAT_OK;
                end
                default:
                begin
                    res_start_reg  <= '0;
                    res_count_reg  <= '0;
                    res_status_reg <= nfpa_pkg::STAT_OOM;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_start_reg  <= res_start_reg;
            out_count_reg  <= res_count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign first_page = out_start_reg;
    assign page_count = out_count_reg;
    assign status     = out_status_reg;

    assign sts.clr_last  = (clr_addr_reg == PW'(PAGES - 1));
    assign sts.is_free   = is_free_reg;
    assign sts.fit_fail  = (end_w >= mp_w - WW'(1));
    assign sts.oom       = wrapped_reg || (cnt_w >= mp_w - WW'(1));
    assign sts.scan_end  = (i_w == end_w);
    assign sts.page_busy = page_rdata;
    assign sts.mark_last = (i_w + WW'(1) == end_w);
    assign sts.free_bad  = (fpage_w >= WW'(PAGES)) || !mark_rdata[LW];
    assign sts.free_end  = (i_w >= fend_w) || (i_w >= WW'(PAGES));

    assign page_we    = cmd.clr_step || cmd.mark_step || cmd.free_step;
    assign page_waddr = cmd.clr_step ? clr_addr_reg : i_reg[PW-1:0];

    assign mark_we    = cmd.clr_step || cmd.mark_start || cmd.free_start;
    assign mark_waddr = cmd.clr_step ? clr_addr_reg
                      : (cmd.mark_start ? cur_reg[PW-1:0] : fpage_w[PW-1:0]);
    assign mark_wdata = {cmd.mark_start,
                         cmd.mark_start ? q_reg[LW-1:0] : mark_rdata[LW-1:0]};

    nfpa_ram #(
        .WIDTH (1),
        .DEPTH (PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (cmd.mark_step),
        .raddr (i_reg[PW-1:0]),
        .rdata (page_rdata)
    );

    nfpa_ram #(
        .WIDTH (LW + 1),
        .DEPTH (PAGES)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (fpage_w[PW-1:0]),
        .rdata (mark_rdata)
    );

endmodule

/* design/next_fit_page_allocator.sv */
// Next-fit page allocator. After reset the block sweeps its page maps and
// accepts no transaction until the sweep ends; the page count register may be
// written meanwhile. PAGE_BYTES must be a power of two. An allocate transaction
// turns bytes into pages with a shift, checks the run against the end of the
// managed range (again after a wrap and after each restart past an occupied
// page), scans the occupancy map from the cursor through the map's registered
// read port, reading each page in S_SCAN_RD and testing it in S_SCAN_CHK, and
// marks the granted run at one page per cycle. A free transaction releases the
// pages of its run; a free of a page that starts no run is rejected. The result
// waits in an output register while the next transaction is taken; a result
// that cannot enter it holds off further input.
module next_fit_page_allocator #(
    parameter int PAGES      = 4096,
    parameter int PAGE_BYTES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [nfpa_pkg::CFG_W-1:0] cfg_write_data,
    nfpa_req_if.sink                   req,
    nfpa_rsp_if.source                 rsp
);

    nfpa_pkg::cmd_t cmd;
    nfpa_pkg::sts_t sts;

    nfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nfpa_dp #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .command        (req.command),
        .request_bytes  (req.request_bytes),
        .free_page      (req.free_page),
        .first_page     (rsp.first_page),
        .page_count     (rsp.page_count),
        .status         (rsp.status),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
